@@ hw/rtl/linear_probe_hash_table_defines.svh @@
// Assertion macros for the hash table RTL.
// No dependencies.
`ifndef LINEAR_PROBE_HASH_TABLE_DEFINES_SVH
`define LINEAR_PROBE_HASH_TABLE_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define LPHT_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("lpht assertion failed");

// Next-cycle implication, disabled during reset.
`define LPHT_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("lpht assertion failed");

`endif

@@ hw/rtl/lpht_pkg.sv @@
// Types, codes and the key mix function for the linear probing hash table.
// No dependencies.
package lpht_pkg;

  localparam int unsigned TABLE_SIZE_DEF = 1024;
  localparam int unsigned HIST_CAP_DEF   = 50;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_LOOKUP = 2'd1,
    OP_BIN    = 2'd2,
    OP_ALT    = 2'd3
  } opcode_t;

  typedef enum logic [2:0] {
    ST_INSERTED = 3'd0,
    ST_PRESENT  = 3'd1,
    ST_FOUND    = 3'd2,
    ST_MISSING  = 3'd3,
    ST_FULL     = 3'd4,
    ST_BIN      = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    RES_WALK   = 2'd0,
    RES_REJECT = 2'd1,
    RES_BIN    = 2'd2
  } res_sel_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_HASH,
    S_RD,
    S_CHK,
    S_FIN,
    S_BIN_RD,
    S_BIN_OUT,
    S_DONE
  } state_t;

  typedef struct packed {
    logic     clear_step;
    logic     load;
    logic     init_walk;
    logic     mem_rd;
    logic     check;
    logic     advance;
    logic     hist_rd_walk;
    logic     hist_rd_bin;
    logic     hist_wr;
    logic     key_wr;
    logic     capture;
    res_sel_t res_sel;
  } cmd_t;

  typedef struct packed {
    logic    clear_last;
    logic    hash_done;
    logic    full;
    opcode_t op;
    logic    hit;
    logic    empty;
    logic    hit_q;
  } sts_t;

  function automatic logic [31:0] key_mix(input logic [31:0] k);
    logic [31:0] h;
    h = k ^ (k >> 20) ^ (k >> 12);
    return h ^ (h >> 7) ^ (h >> 4);
  endfunction

endpackage

@@ hw/rtl/lpht_ctrl.sv @@
// Controller state machine for the hash table: sequences clear, hash,
// probe walk, histogram update, bin read and result strobe. Uses lpht_pkg.
`include "linear_probe_hash_table_defines.svh"
module lpht_ctrl import lpht_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic start,
  output logic busy,
  output logic done,
  input  sts_t sts,
  output cmd_t cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_CLEAR: begin
        if (sts.clear_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (start) state_next = S_HASH;
      end
      S_HASH: begin
        if (sts.op == OP_BIN) begin
          state_next = S_BIN_RD;
        end else if (sts.hash_done) begin
          if (sts.op == OP_INSERT && sts.full) state_next = S_DONE;
          else state_next = S_RD;
        end
      end
      S_RD:      state_next = S_CHK;
      S_CHK: begin
        if (sts.hit || sts.empty) state_next = S_FIN;
        else state_next = S_RD;
      end
      S_FIN:     state_next = S_DONE;
      S_BIN_RD:  state_next = S_BIN_OUT;
      S_BIN_OUT: state_next = S_DONE;
      S_DONE:    state_next = S_IDLE;
      default:   state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    cmd.res_sel = RES_WALK;
    busy = 1'b1;
    done = 1'b0;
    case (state)
      S_CLEAR: cmd.clear_step = 1'b1;
      S_IDLE: begin
        busy = 1'b0;
        cmd.load = start;
      end
      S_HASH: begin
        if (sts.op != OP_BIN && sts.hash_done) begin
          if (sts.op == OP_INSERT && sts.full) begin
            cmd.capture = 1'b1;
            cmd.res_sel = RES_REJECT;
          end else begin
            cmd.init_walk = 1'b1;
          end
        end
      end
      S_RD: cmd.mem_rd = 1'b1;
      S_CHK: begin
        cmd.check = 1'b1;
        if (sts.hit || sts.empty) cmd.hist_rd_walk = (sts.op == OP_INSERT);
        else cmd.advance = 1'b1;
      end
      S_FIN: begin
        cmd.capture = 1'b1;
        cmd.res_sel = RES_WALK;
        if (sts.op == OP_INSERT) begin
          cmd.hist_wr = 1'b1;
          cmd.key_wr  = !sts.hit_q;
        end
      end
      S_BIN_RD: cmd.hist_rd_bin = 1'b1;
      S_BIN_OUT: begin
        cmd.capture = 1'b1;
        cmd.res_sel = RES_BIN;
      end
      S_DONE: done = 1'b1;
      default: ;
    endcase
  end

  `LPHT_ASSERT_NEXT(a_accept_busy, clk, rst, start && !busy, busy)
  `LPHT_ASSERT_NEXT(a_done_idle, clk, rst, done, !busy && !done)
  `LPHT_ASSERT_IMPL(a_write_on_miss, clk, rst, cmd.key_wr, !sts.hit_q && cmd.hist_wr)

endmodule

@@ hw/rtl/lpht_dpath.sv @@
// Datapath for the hash table: key/valid memory, histogram memory, home
// slot reduction, probe pointer and result registers. Uses lpht_pkg.
module lpht_dpath import lpht_pkg::*; #(
  parameter int unsigned TABLE_SIZE = TABLE_SIZE_DEF,
  parameter int unsigned HIST_CAP   = HIST_CAP_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  cmd_t        cmd,
  output sts_t        sts,
  input  logic [1:0]  opcode,
  input  logic [31:0] key,
  input  logic [5:0]  bin_index,
  output logic [2:0]  status,
  output logic [9:0]  slot,
  output logic [9:0]  probe_count,
  output logic [31:0] bin_value
);

  localparam int unsigned IDX_W  = $clog2(TABLE_SIZE);
  localparam int unsigned CNT_W  = $clog2(TABLE_SIZE + 2);
  localparam int unsigned USED_W = $clog2(TABLE_SIZE + 1);
  localparam int unsigned HB_W   = $clog2(HIST_CAP + 1);
  localparam int unsigned HDEPTH = HIST_CAP + 1;
  localparam bit          POW2   = (TABLE_SIZE & (TABLE_SIZE - 1)) == 0;

  opcode_t          op_q;
  logic [31:0]      key_q;
  logic [5:0]       bin_q;
  logic [IDX_W-1:0] home;
  logic             hash_done;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_q  <= opcode_t'(opcode);
      key_q <= key;
      bin_q <= bin_index;
    end
  end

  // Home slot: mask for a power-of-two table, else a reciprocal multiply
  // (quotient estimate low by at most one), a remainder step and a single correction.
  generate
    if (POW2) begin : g_mask
      assign home      = IDX_W'(key_mix(key_q));
      assign hash_done = 1'b1;
    end else begin : g_rem
      localparam logic [31:0] RECIP = 32'((64'd1 << 32) / 64'(TABLE_SIZE));
      logic [31:0] hx;
      logic [31:0] hq;
      logic [31:0] hr;
      logic [63:0] prod;
      logic [1:0]  hcnt;
      assign prod = 64'(hx) * 64'(RECIP);
      always_ff @(posedge clk) begin
        if (rst) begin
          hcnt <= 2'd3;
        end else if (cmd.load) begin
          hcnt <= 2'd0;
        end else if (hcnt != 2'd3) begin
          hcnt <= hcnt + 2'd1;
        end
      end
      always_ff @(posedge clk) begin
        if (cmd.load) begin
          hx <= key_mix(key);
        end else begin
          case (hcnt)
            2'd0: hq <= prod[63:32];
            2'd1: hr <= hx - hq * 32'(TABLE_SIZE);
            2'd2: begin
              if (hr >= 32'(TABLE_SIZE)) hr <= hr - 32'(TABLE_SIZE);
            end
            default: ;
          endcase
        end
      end
      assign home      = IDX_W'(hr);
      assign hash_done = (hcnt == 2'd3);
    end
  endgenerate

  // Key store with valid bit in the top position.
  logic [32:0]      kmem [TABLE_SIZE];
  logic [32:0]      kmem_q;
  logic [IDX_W-1:0] clr_addr;
  logic [IDX_W-1:0] p;
  logic [CNT_W-1:0] cnt;
  logic             hit_q;
  logic             hit;

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (cmd.clear_step) begin
      clr_addr <= clr_addr + IDX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.clear_step) begin
      kmem[clr_addr] <= {1'b0, 32'd0};
    end else if (cmd.key_wr) begin
      kmem[p] <= {1'b1, key_q};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mem_rd) kmem_q <= kmem[p];
  end

  assign hit = kmem_q[32] && (kmem_q[31:0] == key_q);

  always_ff @(posedge clk) begin
    if (cmd.init_walk) begin
      p   <= home;
      cnt <= CNT_W'(1);
    end else if (cmd.advance) begin
      p   <= (p == IDX_W'(TABLE_SIZE - 1)) ? '0 : p + IDX_W'(1);
      cnt <= cnt + CNT_W'(1);
    end
    if (cmd.check) hit_q <= hit;
  end

  logic [USED_W-1:0] used;

  always_ff @(posedge clk) begin
    if (rst) begin
      used <= '0;
    end else if (cmd.key_wr) begin
      used <= used + USED_W'(1);
    end
  end

  // Probe-length histogram with per-bin valid flags.
  logic [31:0]       hmem [HDEPTH];
  logic [31:0]       hmem_q;
  logic [HB_W-1:0]   haddr;
  logic [HDEPTH-1:0] hvalid;
  logic [31:0]       hcur;
  logic [HB_W-1:0]   walk_bin;
  logic              bin_big;

  assign walk_bin = (32'(cnt) >= 32'(HIST_CAP)) ? HB_W'(HIST_CAP) : HB_W'(cnt);
  assign bin_big  = 9'(bin_q) > 9'(HIST_CAP);
  assign hcur     = hvalid[haddr] ? hmem_q : 32'd0;

  always_ff @(posedge clk) begin
    if (cmd.hist_rd_walk) begin
      haddr  <= walk_bin;
      hmem_q <= hmem[walk_bin];
    end else if (cmd.hist_rd_bin) begin
      haddr  <= bin_big ? '0 : HB_W'(bin_q);
      hmem_q <= hmem[bin_big ? '0 : HB_W'(bin_q)];
    end
    if (cmd.hist_wr) begin
      hmem[haddr] <= (hcur == 32'hFFFF_FFFF) ? hcur : hcur + 32'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hvalid <= '0;
    end else if (cmd.hist_wr) begin
      hvalid[haddr] <= 1'b1;
    end
  end

  // Result registers.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      case (cmd.res_sel)
        RES_WALK: begin
          if (op_q == OP_INSERT) status <= hit_q ? ST_PRESENT : ST_INSERTED;
          else status <= hit_q ? ST_FOUND : ST_MISSING;
          slot        <= 10'(p);
          probe_count <= 10'(cnt);
          bin_value   <= 32'd0;
        end
        RES_REJECT: begin
          status      <= ST_FULL;
          slot        <= 10'(home);
          probe_count <= 10'd0;
          bin_value   <= 32'd0;
        end
        RES_BIN: begin
          status      <= ST_BIN;
          slot        <= 10'd0;
          probe_count <= 10'd0;
          if (bin_q == 6'd0) bin_value <= 32'(TABLE_SIZE) - 32'(used);
          else if (bin_big) bin_value <= 32'd0;
          else bin_value <= hcur;
        end
        default: begin
          status      <= ST_BIN;
          slot        <= 10'd0;
          probe_count <= 10'd0;
          bin_value   <= 32'd0;
        end
      endcase
    end
  end

  always_comb begin
    sts.clear_last = (clr_addr == IDX_W'(TABLE_SIZE - 1));
    sts.hash_done  = hash_done;
    sts.full       = ((33'(used) << 1) >= 33'(TABLE_SIZE));
    sts.op         = op_q;
    sts.hit        = hit;
    sts.empty      = !kmem_q[32];
    sts.hit_q      = hit_q;
  end

endmodule

@@ hw/rtl/linear_probe_hash_table.sv @@
// Top level of the linear probing hash table: controller plus datapath.
// Uses lpht_pkg, lpht_ctrl and lpht_dpath.
//
//   channel   handshake          payload
//   command   start / busy       opcode, key, bin_index
//   result    done (one cycle)   status, slot, probe_count, bin_value
//
// A bin read passes S_HASH, S_BIN_RD and S_BIN_OUT before the done strobe. An
// insert or lookup passes S_HASH, an S_RD/S_CHK pair per probe (key memory read
// and compare) and S_FIN; a rejected insert goes from S_HASH to S_DONE. With a
// non-power-of-two table S_HASH also waits for the reciprocal multiplication.
// Each done is followed by a return to idle. After reset the key memory is
// cleared one slot a cycle with busy high. The receiver cannot stall results.
module linear_probe_hash_table import lpht_pkg::*; #(
  parameter int unsigned TABLE_SIZE = TABLE_SIZE_DEF,
  parameter int unsigned HIST_CAP   = HIST_CAP_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  opcode,
  input  logic [31:0] key,
  input  logic [5:0]  bin_index,
  output logic        done,
  output logic [2:0]  status,
  output logic [9:0]  slot,
  output logic [9:0]  probe_count,
  output logic [31:0] bin_value
);

  cmd_t cmd;
  sts_t sts;

  lpht_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .done  (done),
    .sts   (sts),
    .cmd   (cmd)
  );

  lpht_dpath #(
    .TABLE_SIZE (TABLE_SIZE),
    .HIST_CAP   (HIST_CAP)
  ) u_dpath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .sts         (sts),
    .opcode      (opcode),
    .key         (key),
    .bin_index   (bin_index),
    .status      (status),
    .slot        (slot),
    .probe_count (probe_count),
    .bin_value   (bin_value)
  );

endmodule

@@ bench/hash_table_checker.sv @@
// Checker for the linear probing hash table: watches command and result traffic,
// predicts each result from its own copy of the table and compares. Uses lpht_pkg.
`timescale 1ns / 100ps
module hash_table_checker import lpht_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic        busy,
  input  logic [1:0]  opcode,
  input  logic [31:0] key,
  input  logic [5:0]  bin_index,
  input  logic        done,
  input  logic [2:0]  status,
  input  logic [9:0]  slot,
  input  logic [9:0]  probe_count,
  input  logic [31:0] bin_value,
  output int          errors,
  output int          pending
);
  localparam int unsigned SLOTS = TABLE_SIZE_DEF;
  localparam int unsigned CAP   = HIST_CAP_DEF;

  typedef struct packed {
    status_t     st;
    logic [9:0]  pos;
    logic [9:0]  cnt;
    logic [31:0] val;
  } answer_t;

  logic [31:0] keys [SLOTS];
  logic        used [SLOTS];
  int unsigned occupancy;
  logic [31:0] hist [CAP+1];
  answer_t     awaited [$];

  function automatic int unsigned home_of(logic [31:0] k);
    logic [31:0] h;
    h = k ^ (k >> 20) ^ (k >> 12);
    h = h ^ (h >> 7) ^ (h >> 4);
    return h % SLOTS;
  endfunction

  function automatic bit walk(logic [31:0] k, output int unsigned p, output int unsigned c);
    p = home_of(k);
    c = 1;
    while (used[p] && c <= SLOTS) begin
      if (keys[p] == k) return 1;
      c++;
      p = (p + 1) % SLOTS;
    end
    return 0;
  endfunction

  function automatic answer_t apply_command(opcode_t op, logic [31:0] k, logic [5:0] b);
    answer_t a;
    int unsigned p, c, hb;
    bit hit;
    a = '0;
    if (op == OP_BIN) begin
      a.st = ST_BIN;
      if (b == 0) a.val = 32'(SLOTS - occupancy);
      else if (b <= CAP) a.val = hist[b];
    end else if (op == OP_INSERT) begin
      if (occupancy * 2 >= SLOTS) begin
        a.st = ST_FULL;
        a.pos = 10'(home_of(k));
      end else begin
        hit = walk(k, p, c);
        hb = (c > CAP - 1) ? CAP : c;
        if (hist[hb] != 32'hFFFF_FFFF) hist[hb]++;
        a.pos = 10'(p);
        a.cnt = 10'(c);
        if (hit) a.st = ST_PRESENT;
        else begin
          a.st = ST_INSERTED;
          keys[p] = k;
          used[p] = 1;
          occupancy++;
        end
      end
    end else begin
      hit = walk(k, p, c);
      a.st = hit ? ST_FOUND : ST_MISSING;
      a.pos = 10'(p);
      a.cnt = 10'(c);
    end
    return a;
  endfunction

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    errors++;
  endtask

  initial begin
    errors = 0;
    occupancy = 0;
    foreach (used[i]) used[i] = 0;
    foreach (hist[i]) hist[i] = 0;
  end

  assign pending = awaited.size();

  always @(posedge clk) begin
    answer_t e;
    if (!rst) begin
      if (done) begin
        if (awaited.size() == 0) report("unexpected transaction", 32'(status), 32'd0);
        else begin
          e = awaited.pop_front();
          if (status !== e.st) report("status", 32'(status), 32'(e.st));
          if (slot !== e.pos) report("slot", 32'(slot), 32'(e.pos));
          if (probe_count !== e.cnt) report("probe_count", 32'(probe_count), 32'(e.cnt));
          if (bin_value !== e.val) report("bin_value", bin_value, e.val);
        end
      end
      if (start && !busy) awaited.push_back(apply_command(opcode_t'(opcode), key, bin_index));
    end
  end
endmodule

@@ bench/testbench.sv @@
// Top of the hash table bench: clock, reset, command stimulus and verdict.
// Uses lpht_pkg, linear_probe_hash_table and hash_table_checker.
`timescale 1ns / 100ps
module testbench import lpht_pkg::*;;
  logic        clk = 0, rst = 1, start = 0;
  logic [1:0]  opcode = OP_INSERT;
  logic [31:0] key = '0;
  logic [5:0]  bin_index = '0;
  logic        busy, done;
  logic [2:0]  status;
  logic [9:0]  slot, probe_count;
  logic [31:0] bin_value;
  int          errors, pending;
  logic [31:0] known [$];

  always #4 clk = ~clk;

  linear_probe_hash_table dut (.*);
  hash_table_checker chk (.*);

  task automatic issue(opcode_t op, logic [31:0] k, logic [5:0] b);
    int gap;
    gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 2);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      start <= 0;
      repeat (gap) @(posedge clk);
    end
    start <= 1; opcode <= op; key <= k; bin_index <= b;
    do @(posedge clk); while (busy);
    if (op == OP_INSERT) known.push_back(k);
  endtask

  function automatic logic [31:0] pick_key();
    int r;
    r = $urandom_range(0, 9);
    if (known.size() > 0 && r < 4) return known[$urandom_range(0, known.size() - 1)];
    if (r < 6) return {2'($urandom_range(0, 3)), 20'h0, 10'($urandom_range(0, 7))};
    return $urandom;
  endfunction

  initial begin
    int r;
    repeat (9) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    issue(OP_BIN, 0, 0);
    issue(OP_LOOKUP, 32'h0, 0);
    issue(OP_INSERT, 32'h0, 0);
    issue(OP_INSERT, 32'hFFFF_FFFF, 0);
    issue(OP_INSERT, 32'h0, 0);
    issue(OP_LOOKUP, 32'hFFFF_FFFF, 0);
    issue(OP_ALT, 32'h0, 0);
    issue(OP_ALT, 32'h1234_5678, 0);
    for (int i = 0; i < 6; i++) issue(OP_INSERT, 32'h0010_0000 * i, 0);
    issue(OP_LOOKUP, 32'h0060_0000, 0);
    issue(OP_BIN, 0, 1);
    issue(OP_BIN, 0, 2);
    issue(OP_BIN, 0, 50);
    issue(OP_BIN, 0, 51);
    issue(OP_BIN, 0, 63);
    issue(OP_BIN, 0, 0);
    for (int i = 0; i < 250; i++) begin
      r = $urandom_range(0, 9);
      if (r < 5) issue(OP_INSERT, pick_key(), 0);
      else if (r < 8) issue(($urandom_range(0, 3) == 0) ? OP_ALT : OP_LOOKUP, pick_key(), 0);
      else issue(OP_BIN, 0, 6'($urandom_range(0, 63)));
    end
    // fill to the load limit so that full rejection and long walks appear
    for (int i = 0; i < 470; i++) issue(OP_INSERT, $urandom, 0);
    issue(OP_INSERT, known[0], 0);
    issue(OP_INSERT, 32'hFFFF_FFFF, 0);
    for (int b = 0; b <= 51; b++) issue(OP_BIN, 0, 6'(b));
    for (int i = 0; i < 40; i++) issue(OP_LOOKUP, pick_key(), 0);
    start <= 0;
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (errors == 0) $display("PASSED: all results match");
    else $display("FAILED: results differ");
    $finish;
  end

  initial begin
    #40ms;
    $display("FAILED: results differ");
    $finish;
  end
endmodule

@@ filelist.f @@
+incdir+hw/rtl
hw/rtl/lpht_pkg.sv
hw/rtl/lpht_ctrl.sv
hw/rtl/lpht_dpath.sv
hw/rtl/linear_probe_hash_table.sv
bench/hash_table_checker.sv
bench/testbench.sv
